// ===== sv/hbt_pkg.sv =====
`timescale 1ns / 1ps

package hbt_pkg;

    localparam int NODE_W    = 16;
    localparam int AGE_W     = 32;
    localparam int MAX_AGE_W = 32;
    localparam int REG_IDX_W = 1;
    localparam int OP_W      = 2;

    localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET = 32'd1000;

    localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK      = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK     = 2'd2;
    localparam logic [OP_W-1:0] OP_INIT      = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_MAX_AGE   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_CATCH_ALL = 1'd1;

    localparam logic KIND_FAILED = 1'b0;
    localparam logic KIND_NONE   = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              seen;
        logic [NODE_W-1:0] node;
    } entry_tag_t;

    typedef struct packed {
        logic rotate;
        logic heartbeat;
        logic append;
        logic init;
        logic preset;
    } cell_ctl_t;

endpackage

// ===== sv/hbt_if.sv =====
`timescale 1ns / 1ps

interface hbt_in_if;
    logic                          valid;
    logic                          ready;
    logic [hbt_pkg::OP_W-1:0]      op;
    logic [hbt_pkg::NODE_W-1:0]    node_id;

    modport source (output valid, output op, output node_id, input ready);
    modport sink   (input valid, input op, input node_id, output ready);
endinterface

interface hbt_out_if;
    logic                          valid;
    logic                          ready;
    logic [hbt_pkg::NODE_W-1:0]    failed_node;
    logic                          kind;
    logic [hbt_pkg::AGE_W-1:0]     node_age;
    logic                          last;

    modport source (output valid, output failed_node, output kind, output node_age,
                    output last, input ready);
    modport sink   (input valid, input failed_node, input kind, input node_age,
                    input last, output ready);
endinterface

// ===== sv/hbt_cell.sv =====
`timescale 1ns / 1ps

module hbt_cell #(
    parameter int CELL_INDEX = 0,
    parameter bit PRESET_EN  = 1'b0,
    parameter int TIME_BITS  = 32,
    parameter int CNT_BITS   = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hbt_pkg::cell_ctl_t         ctl,
    input  logic [CNT_BITS-1:0]        append_idx,
    input  logic [hbt_pkg::NODE_W-1:0] hb_node,
    input  logic [TIME_BITS-1:0]       now_time,
    input  hbt_pkg::entry_tag_t        nbr_tag,
    input  logic [TIME_BITS-1:0]       nbr_time,
    output hbt_pkg::entry_tag_t        tag,
    output logic [TIME_BITS-1:0]       time_val,
    output logic                       match
);
    import hbt_pkg::*;

    logic                 valid_reg, valid_next;
    logic                 seen_reg, seen_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 append_here;

    assign match       = valid_reg && (node_reg == hb_node);
    assign append_here = ctl.append && (append_idx == CNT_BITS'(CELL_INDEX));

    always_comb
    begin
        valid_next = valid_reg;
        seen_next  = seen_reg;
        node_next  = node_reg;
        time_next  = time_reg;
        if (ctl.init)
        begin
            valid_next = PRESET_EN && ctl.preset;
            seen_next  = 1'b0;
            node_next  = NODE_W'(CELL_INDEX);
            time_next  = '0;
        end
        else if (ctl.rotate)
        begin
            valid_next = nbr_tag.valid;
            seen_next  = nbr_tag.seen;
            node_next  = nbr_tag.node;
            time_next  = nbr_time;
        end
        else if (ctl.heartbeat && match)
        begin
            seen_next = 1'b1;
            time_next = now_time;
        end
        else if (append_here)
        begin
            valid_next = 1'b1;
            seen_next  = 1'b1;
            node_next  = hb_node;
            time_next  = now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        time_reg <= time_next;
    end

    assign tag.valid = valid_reg;
    assign tag.seen  = seen_reg;
    assign tag.node  = node_reg;
    assign time_val  = time_reg;

endmodule

// ===== sv/heartbeat_timeout_monitor.sv =====
`timescale 1ns / 1ps
// channel | dir | fields                                | accepted when
// in      | in  | op, node_id                           | in.valid && in.ready
// out     | out | failed_node, kind, node_age, last     | out.valid && out.ready
// cfg     | in  | cfg_index, cfg_data                   | cfg_wr_en
//
// Heartbeat, tick and init complete without leaving the idle state.
// A check rotates the cell ring once, then moves to a flush state to send the
// final item; the ring holds while out stalls on a pending hit.
// Reset empties the table and clears the time counter.
// A result left waiting on out does not block the next heartbeat or tick.

module heartbeat_timeout_monitor #(
    parameter int TABLE_ENTRIES = 64,
    parameter int PRESET_NODES  = 49,
    parameter int TIME_BITS     = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hbt_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [hbt_pkg::MAX_AGE_W-1:0] cfg_data,
    hbt_in_if.sink                        in,
    hbt_out_if.source                     out
);
    import hbt_pkg::*;

    localparam int IDX_BITS     = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS     = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_BITS     = (TIME_BITS > MAX_AGE_W) ? TIME_BITS : MAX_AGE_W;
    localparam int PRESET_COUNT = (PRESET_NODES < TABLE_ENTRIES) ? PRESET_NODES
                                                                 : TABLE_ENTRIES;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [IDX_BITS-1:0]  step_reg, step_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [MAX_AGE_W-1:0] max_age_reg;
    logic                 catch_all_reg;

    logic                 pend_v_reg, pend_v_next;
    logic [NODE_W-1:0]    pend_node_reg, pend_node_next;
    logic [AGE_W-1:0]     pend_age_reg, pend_age_next;

    logic                 out_v_reg, out_v_next;
    logic [NODE_W-1:0]    out_node_reg, out_node_next;
    logic                 out_kind_reg, out_kind_next;
    logic [AGE_W-1:0]     out_age_reg, out_age_next;
    logic                 out_last_reg, out_last_next;

    entry_tag_t           cell_tag [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] cell_time [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] cell_match;
    cell_ctl_t            ctl;

    logic                 in_fire;
    logic                 found;
    logic [TIME_BITS-1:0] head_age;
    logic [CMP_BITS-1:0]  head_age_ext;
    logic                 hit;
    logic                 can_load;
    logic                 step;

    assign in.ready = (state_reg == ST_IDLE);
    assign in_fire  = in.valid && in.ready;
    assign found    = |cell_match;

    assign head_age     = now_reg - cell_time[0];
    assign head_age_ext = CMP_BITS'(head_age);
    assign hit          = cell_tag[0].valid && cell_tag[0].seen
                          && (head_age_ext >= CMP_BITS'(max_age_reg));
    assign can_load     = !out_v_reg || out.ready;
    assign step         = (state_reg == ST_SCAN) && (!hit || !pend_v_reg || can_load);

    always_comb
    begin
        ctl.rotate    = step;
        ctl.heartbeat = in_fire && (in.op == OP_HEARTBEAT);
        ctl.append    = in_fire && (in.op == OP_HEARTBEAT) && !found && catch_all_reg
                        && (count_reg < CNT_BITS'(TABLE_ENTRIES));
        ctl.init      = in_fire && (in.op == OP_INIT);
        ctl.preset    = !catch_all_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            localparam int NXT = (gi + 1) % TABLE_ENTRIES;
            hbt_cell #(
                .CELL_INDEX (gi),
                .PRESET_EN  (gi < PRESET_COUNT),
                .TIME_BITS  (TIME_BITS),
                .CNT_BITS   (CNT_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .append_idx (count_reg),
                .hb_node    (in.node_id),
                .now_time   (now_reg),
                .nbr_tag    (cell_tag[NXT]),
                .nbr_time   (cell_time[NXT]),
                .tag        (cell_tag[gi]),
                .time_val   (cell_time[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        now_next       = now_reg;
        pend_v_next    = pend_v_reg;
        pend_node_next = pend_node_reg;
        pend_age_next  = pend_age_reg;
        out_v_next     = out_v_reg && !out.ready;
        out_node_next  = out_node_reg;
        out_kind_next  = out_kind_reg;
        out_age_next   = out_age_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in.op)
                        OP_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        OP_CHECK:
                        begin
                            state_next  = ST_SCAN;
                            step_next   = '0;
                            pend_v_next = 1'b0;
                        end
                        OP_INIT:
                        begin
                            count_next = catch_all_reg ? '0 : CNT_BITS'(PRESET_COUNT);
                        end
                        OP_HEARTBEAT:
                        begin
                            if (ctl.append)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    if (hit)
                    begin
                        if (pend_v_reg)
                        begin
                            out_v_next    = 1'b1;
                            out_node_next = pend_node_reg;
                            out_kind_next = KIND_FAILED;
                            out_age_next  = pend_age_reg;
                            out_last_next = 1'b0;
                        end
                        pend_v_next    = 1'b1;
                        pend_node_next = cell_tag[0].node;
                        pend_age_next  = head_age_ext[AGE_W-1:0];
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == IDX_BITS'(TABLE_ENTRIES - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (can_load)
                begin
                    out_v_next    = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_v_reg)
                    begin
                        out_node_next = pend_node_reg;
                        out_kind_next = KIND_FAILED;
                        out_age_next  = pend_age_reg;
                    end
                    else
                    begin
                        out_node_next = '0;
                        out_kind_next = KIND_NONE;
                        out_age_next  = '0;
                    end
                    pend_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            now_reg       <= '0;
            pend_v_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
            max_age_reg   <= MAX_AGE_RESET;
            catch_all_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            now_reg    <= now_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MAX_AGE:   max_age_reg   <= cfg_data;
                    REG_CATCH_ALL: catch_all_reg <= cfg_data[0];
                    default:       max_age_reg   <= max_age_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_node_reg <= pend_node_next;
        pend_age_reg  <= pend_age_next;
        out_node_reg  <= out_node_next;
        out_kind_reg  <= out_kind_next;
        out_age_reg   <= out_age_next;
        out_last_reg  <= out_last_next;
    end

    assign out.valid       = out_v_reg;
    assign out.failed_node = out_node_reg;
    assign out.kind        = out_kind_reg;
    assign out.node_age    = out_age_reg;
    assign out.last        = out_last_reg;

endmodule

// ===== sv/hbt_checker.sv =====
`timescale 1ns / 1ps

module hbt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [hbt_pkg::OP_W-1:0]      in_op,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [hbt_pkg::NODE_W-1:0]    out_failed_node,
    input logic                          out_kind,
    input logic [hbt_pkg::AGE_W-1:0]     out_node_age,
    input logic                          out_last
);
    import hbt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_node_age) && $stable(out_last))
        else $error("result changed while stalled");

    a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_NONE)
        |-> out_last && (out_failed_node == '0) && (out_node_age == '0))
        else $error("malformed none result");

    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == OP_CHECK) |=> !in_ready)
        else $error("input taken during check scan");

endmodule

bind heartbeat_timeout_monitor hbt_checker u_hbt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in.valid),
    .in_ready        (in.ready),
    .in_op           (in.op),
    .out_valid       (out.valid),
    .out_ready       (out.ready),
    .out_failed_node (out.failed_node),
    .out_kind        (out.kind),
    .out_node_age    (out.node_age),
    .out_last        (out.last)
);
